### hdl/dsvrft_pkg.sv
// shared types and constants for the delimiter-separated row tokenizer
`default_nettype none
package dsvrft_pkg;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam int unsigned MAX_TOKENS = 3;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } token_kind_t;

endpackage
`default_nettype wire

### hdl/dsv_row_field_tokenizer_core.sv
// top level of the delimiter-separated row tokenizer
`default_nettype none
// Takes one source byte per word on the s_ side (s_tlast marks the last byte of a
// source and flushes the open row) and sends field characters, field ends and row
// ends on the m_ side, m_tlast marking the final word caused by one byte. A byte
// sits in an input register, is decoded combinationally into a group of zero to
// three words, and the group is sent from a result register one word per cycle
// while m_tready is high. Bytes causing zero or one word then go through at one
// byte per cycle; a byte causing more words holds the result register until its
// last word is taken, so the output port sets the rate. The user must write the
// delimiter (cfg_ port, reset ',') only while idle; the block does not enforce it.
module dsv_row_field_tokenizer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,   // delimiter_char
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,    // in_byte
  input  wire logic       s_tlast,    // end_of_source
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,    // out_char
  output logic [1:0]      m_tuser,    // token_kind
  output logic            m_tlast     // last_of_run
);

  logic [7:0] delimiter_char;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;

  logic inside_quotes, quote_pending, skip_next_lf, field_has_chars, row_has_fields;
  logic inside_quotes_next, quote_pending_next, skip_next_lf_next;
  logic field_has_chars_next, row_has_fields_next;

  dsvrft_pkg::token_kind_t tok_kind_next [dsvrft_pkg::MAX_TOKENS];
  logic [7:0]              tok_char_next [dsvrft_pkg::MAX_TOKENS];
  logic [1:0]              tok_cnt_next;

  logic                    grp_valid;
  dsvrft_pkg::token_kind_t grp_kind [dsvrft_pkg::MAX_TOKENS];
  logic [7:0]              grp_char [dsvrft_pkg::MAX_TOKENS];
  logic [1:0]              grp_cnt;
  logic [1:0]              pos;

  logic grp_last;
  logic grp_load;
  logic used;
  logic row_any;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= dsvrft_pkg::DELIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delimiter_char <= cfg_data;
    end
  end

  // input register
  assign grp_last = (pos == grp_cnt - 2'd1);
  assign grp_load = in_valid && (!grp_valid || (grp_last && m_tready));
  assign s_tready = !in_valid || grp_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
  end

  // decode one byte into up to three words
  always_comb begin
    inside_quotes_next   = inside_quotes;
    quote_pending_next   = quote_pending;
    skip_next_lf_next    = 1'b0;
    field_has_chars_next = field_has_chars;
    row_has_fields_next  = row_has_fields;
    tok_cnt_next         = 2'd0;
    used                 = 1'b0;
    row_any              = 1'b0;
    for (int i = 0; i < dsvrft_pkg::MAX_TOKENS; i++) begin
      tok_kind_next[i] = dsvrft_pkg::KIND_CHAR;
      tok_char_next[i] = 8'd0;
    end

    if (skip_next_lf && in_byte == dsvrft_pkg::CH_LF) begin
      used = 1'b1;
    end

    if (!used && quote_pending) begin
      quote_pending_next = 1'b0;
      if (in_byte == dsvrft_pkg::CH_QUOTE) begin
        tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_CHAR;
        tok_char_next[tok_cnt_next] = dsvrft_pkg::CH_QUOTE;
        tok_cnt_next                = tok_cnt_next + 2'd1;
        field_has_chars_next        = 1'b1;
        used                        = 1'b1;
      end else begin
        inside_quotes_next = !inside_quotes_next;
      end
    end

    if (!used) begin
      priority if (in_byte == dsvrft_pkg::CH_QUOTE) begin
        if (in_eos) begin
          inside_quotes_next = !inside_quotes_next;
        end else begin
          quote_pending_next = 1'b1;
        end
      end else if (in_byte == dsvrft_pkg::CH_LF || in_byte == dsvrft_pkg::CH_CR) begin
        if (!in_eos) begin
          if (inside_quotes_next) begin
            tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_CHAR;
            tok_char_next[tok_cnt_next] = in_byte;
            tok_cnt_next                = tok_cnt_next + 2'd1;
            field_has_chars_next        = 1'b1;
          end else begin
            row_any = row_has_fields_next || field_has_chars_next;
            if (field_has_chars_next) begin
              tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_FIELD_END;
              tok_cnt_next                = tok_cnt_next + 2'd1;
            end
            if (row_any) begin
              tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_ROW_END;
              tok_cnt_next                = tok_cnt_next + 2'd1;
            end
            field_has_chars_next = 1'b0;
            row_has_fields_next  = 1'b0;
            inside_quotes_next   = 1'b0;
            skip_next_lf_next    = (in_byte == dsvrft_pkg::CH_CR);
          end
        end
      end else if (in_byte == delimiter_char && !inside_quotes_next) begin
        tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_FIELD_END;
        tok_cnt_next                = tok_cnt_next + 2'd1;
        row_has_fields_next         = 1'b1;
        field_has_chars_next        = 1'b0;
      end else begin
        tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_CHAR;
        tok_char_next[tok_cnt_next] = in_byte;
        tok_cnt_next                = tok_cnt_next + 2'd1;
        field_has_chars_next        = 1'b1;
      end
    end

    // flush at end of source
    if (in_eos) begin
      row_any = row_has_fields_next || field_has_chars_next;
      if (field_has_chars_next) begin
        tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_FIELD_END;
        tok_cnt_next                = tok_cnt_next + 2'd1;
      end
      if (row_any) begin
        tok_kind_next[tok_cnt_next] = dsvrft_pkg::KIND_ROW_END;
        tok_cnt_next                = tok_cnt_next + 2'd1;
      end
      inside_quotes_next   = 1'b0;
      quote_pending_next   = 1'b0;
      skip_next_lf_next    = 1'b0;
      field_has_chars_next = 1'b0;
      row_has_fields_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes   <= 1'b0;
      quote_pending   <= 1'b0;
      skip_next_lf    <= 1'b0;
      field_has_chars <= 1'b0;
      row_has_fields  <= 1'b0;
    end else if (grp_load) begin
      inside_quotes   <= inside_quotes_next;
      quote_pending   <= quote_pending_next;
      skip_next_lf    <= skip_next_lf_next;
      field_has_chars <= field_has_chars_next;
      row_has_fields  <= row_has_fields_next;
    end
  end

  // result register, one word per cycle while m_tready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (grp_load) begin
      grp_valid <= (tok_cnt_next != 2'd0);
      pos       <= 2'd0;
    end else if (grp_valid && m_tready) begin
      if (grp_last) begin
        grp_valid <= 1'b0;
        pos       <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_kind <= tok_kind_next;
      grp_char <= tok_char_next;
      grp_cnt  <= tok_cnt_next;
    end
  end

  assign m_tvalid = grp_valid;
  assign m_tuser  = grp_kind[pos];
  assign m_tdata  = grp_char[pos];
  assign m_tlast  = grp_last;

endmodule
`default_nettype wire

### hdl/dsvrft_checker.sv
// port checker for the delimiter-separated row tokenizer and its bind
`default_nettype none
module dsvrft_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [1:0] m_tuser,
  input wire logic       m_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output word changed");

  // only field characters carry a byte
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != dsvrft_pkg::KIND_CHAR |-> m_tdata == 8'd0)
    else $error("non-character word carries data");

  // a row end closes the run of its byte
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == dsvrft_pkg::KIND_ROW_END |-> m_tlast)
    else $error("row end not last of run");

  // a field end inside a run is followed at once by the row end
  a_fe_then_re: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == dsvrft_pkg::KIND_FIELD_END && !m_tlast
      |=> m_tvalid && m_tuser == dsvrft_pkg::KIND_ROW_END)
    else $error("field end inside run not followed by row end");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind dsv_row_field_tokenizer_core dsvrft_checker u_dsvrft_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

### tb/dsv_row_field_tokenizer_core_test.sv
// testbench for the row field tokenizer core: predicted token words checked under random stalls
`timescale 1ns / 1ps
module dsv_row_field_tokenizer_core_test;

  typedef struct {
    dsvrft_pkg::token_kind_t kind;
    logic [7:0]              ch;
    logic                    last;
  } token_word_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
  } src_word_t;

  class row_token_board;
    logic [7:0]  delim;
    bit          in_quotes;
    bit          quote_held;
    bit          drop_lf;
    bit          field_open;
    bit          row_open;
    token_word_t expected[$];
    token_word_t run_buf[$];
    int          errors;
    int          bytes_noted;
    int          words_checked;

    function new();
      delim = dsvrft_pkg::DELIM_RESET;
      errors = 0;
      bytes_noted = 0;
      words_checked = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void add_token(dsvrft_pkg::token_kind_t k, logic [7:0] c);
      token_word_t tok;
      if (run_buf.size() < dsvrft_pkg::MAX_TOKENS) begin
        tok.kind = k;
        tok.ch = c;
        tok.last = 1'b0;
        run_buf.insert(run_buf.size(), tok);
      end
    endfunction

    function void put_char(logic [7:0] c);
      add_token(dsvrft_pkg::KIND_CHAR, c);
      field_open = 1'b1;
    endfunction

    function void close_row();
      bit any;
      any = row_open || field_open;
      if (field_open) add_token(dsvrft_pkg::KIND_FIELD_END, 8'h00);
      if (any) add_token(dsvrft_pkg::KIND_ROW_END, 8'h00);
      field_open = 1'b0;
      row_open = 1'b0;
      in_quotes = 1'b0;
    endfunction

    // one accepted source byte, expected words appended in order
    function void note_byte(logic [7:0] b, logic eos);
      bit          used;
      token_word_t tok;
      int          i;
      used = 1'b0;
      run_buf.delete();
      bytes_noted++;
      if (drop_lf && b == dsvrft_pkg::CH_LF) used = 1'b1;
      drop_lf = 1'b0;
      if (!used && quote_held) begin
        quote_held = 1'b0;
        if (b == dsvrft_pkg::CH_QUOTE) begin
          put_char(dsvrft_pkg::CH_QUOTE);
          used = 1'b1;
        end else begin
          in_quotes = !in_quotes;
        end
      end
      if (!used) begin
        if (b == dsvrft_pkg::CH_QUOTE) begin
          if (eos) in_quotes = !in_quotes;
          else quote_held = 1'b1;
        end else if (b == dsvrft_pkg::CH_LF || b == dsvrft_pkg::CH_CR) begin
          if (!eos) begin
            if (in_quotes) begin
              put_char(b);
            end else begin
              close_row();
              if (b == dsvrft_pkg::CH_CR) drop_lf = 1'b1;
            end
          end
        end else if (b == delim && !in_quotes) begin
          add_token(dsvrft_pkg::KIND_FIELD_END, 8'h00);
          row_open = 1'b1;
          field_open = 1'b0;
        end else begin
          put_char(b);
        end
      end
      if (eos) begin
        close_row();
        in_quotes = 1'b0;
        quote_held = 1'b0;
        drop_lf = 1'b0;
        field_open = 1'b0;
        row_open = 1'b0;
      end
      for (i = 0; i < run_buf.size(); i++) begin
        tok = run_buf[i];
        tok.last = (i == run_buf.size() - 1);
        expected.insert(expected.size(), tok);
      end
    endfunction

    function void check_word(logic [1:0] kind, logic [7:0] ch, logic last);
      token_word_t exp_w;
      words_checked++;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind %0d char %02h last %0b", $time, kind, ch, last);
      end else begin
        exp_w = expected.pop_front();
        if (exp_w.kind !== kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, kind);
        end
        if (exp_w.ch !== ch) begin
          errors++;
          $display("%0t: char expected %02h actual %02h", $time, exp_w.ch, ch);
        end
        if (exp_w.last !== last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, exp_w.last, last);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  row_token_board board;
  src_word_t      stim[$];
  int             burst_left = 0;
  int             settings_done = 0;
  bit             hold_req = 1'b0;

  dsv_row_field_tokenizer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_word(m_tuser, m_tdata, m_tlast);
      if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) board.delim = cfg_data;
    end
  end

  // receiver: stall modes that change now and then, plus a long hold on request
  initial begin : receiver
    int hold_left;
    int cnt;
    int rx_mode;
    hold_left = 0;
    cnt = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk);
      cnt++;
      if (cnt % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (cnt[2:0] != 3'd0);
        endcase
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d words still expected", board.pending());
    $display("dsv_row_field_tokenizer_core_test NOT OK");
    $finish;
  end

  task automatic push_word(logic [7:0] b, logic eos);
    src_word_t w;
    w.b = b;
    w.eos = eos;
    stim.insert(stim.size(), w);
  endtask

  task automatic gen_quoted(logic [7:0] d);
    int n;
    int i;
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        5: push_word(d, 1'b0);
        6: begin
          push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
          push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
        end
        7: push_word(dsvrft_pkg::CH_LF, 1'b0);
        8: push_word(dsvrft_pkg::CH_CR, 1'b0);
        9: push_word(8'($urandom_range(0, 255)), 1'b0);
        default: push_word(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      endcase
    end
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
  endtask

  task automatic gen_row(logic [7:0] d);
    int        nf;
    int        nc;
    int        f;
    int        i;
    src_word_t w;
    nf = $urandom_range(0, 4);
    for (f = 0; f < nf; f++) begin
      if (f > 0) push_word(d, 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        gen_quoted(d);
      end else begin
        nc = $urandom_range(0, 4);
        for (i = 0; i < nc; i++) begin
          if ($urandom_range(0, 7) == 0) push_word(8'($urandom_range(0, 255)), 1'b0);
          else push_word(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        end
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2: push_word(dsvrft_pkg::CH_LF, 1'b0);
      3, 4: push_word(dsvrft_pkg::CH_CR, 1'b0);
      5, 6, 7: begin
        push_word(dsvrft_pkg::CH_CR, 1'b0);
        push_word(dsvrft_pkg::CH_LF, 1'b0);
      end
      8: push_word(dsvrft_pkg::CH_LF, 1'b1);
      default: begin
        if (stim.size() > 0) begin
          w = stim.pop_back();
          w.eos = 1'b1;
          stim.insert(stim.size(), w);
        end
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      nc = $urandom_range(1, 3);
      for (i = 0; i < nc; i++) begin
        push_word(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      end
    end
  endtask

  task automatic gen_rows(logic [7:0] d, int count);
    while (stim.size() < count) gen_row(d);
  endtask

  task automatic send_stim();
    int i;
    int gap;
    for (i = 0; i < stim.size(); i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      s_tvalid <= 1'b1;
      s_tdata <= stim[i].b;
      s_tlast <= stim[i].eos;
      do @(posedge clk); while (!s_tready);
      burst_left--;
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    stim.delete();
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_delimiter(logic [7:0] d);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  initial begin : main
    logic [7:0] delims[8];
    int         p;
    int         guard;
    board = new();
    delims[0] = 8'h00;
    delims[1] = 8'hFF;
    delims[2] = dsvrft_pkg::CH_QUOTE;
    delims[3] = ";";
    delims[4] = dsvrft_pkg::CH_LF;
    delims[5] = dsvrft_pkg::CH_CR;
    delims[6] = 8'($urandom_range(0, 255));
    delims[7] = dsvrft_pkg::DELIM_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with the reset delimiter
    push_word("a", 1'b0);
    push_word(",", 1'b0);
    push_word("b", 1'b0);
    push_word(dsvrft_pkg::CH_LF, 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(",", 1'b0);
    push_word(dsvrft_pkg::CH_LF, 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(dsvrft_pkg::CH_CR, 1'b0);
    push_word(dsvrft_pkg::CH_LF, 1'b0);
    push_word(dsvrft_pkg::CH_LF, 1'b0);
    push_word(",", 1'b0);
    push_word(dsvrft_pkg::CH_CR, 1'b0);
    push_word(dsvrft_pkg::CH_CR, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(8'hFF, 1'b1);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b1);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b0);
    push_word(dsvrft_pkg::CH_LF, 1'b1);
    push_word("z", 1'b0);
    push_word(dsvrft_pkg::CH_QUOTE, 1'b1);
    send_stim();

    for (p = 0; p < 8; p++) begin
      write_delimiter(delims[p]);
      if (p == 1) hold_req = 1'b1;
      gen_rows(delims[p], 9);
      send_stim();
      if (p == 3) wait_drained();
      gen_rows(delims[p], 9);
      send_stim();
    end

    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d expected words never arrived", $time, board.pending());
    end

    $display("sent %0d source bytes under %0d delimiter settings, checked %0d token words",
             board.bytes_noted, settings_done + 1, board.words_checked);
    if (board.errors == 0) begin
      $display("dsv_row_field_tokenizer_core_test OK");
    end else begin
      $display("dsv_row_field_tokenizer_core_test NOT OK");
    end
    $finish;
  end

endmodule
